/* rtl/integer_literal_parser_top_macros.svh */
// assertion macros shared by the integer literal parser rtl
// expects clk and arst_n in the scope of each use
`ifndef INTEGER_LITERAL_PARSER_TOP_MACROS_SVH
`define INTEGER_LITERAL_PARSER_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define ILP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define ILP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/ilp_pkg.sv */
// types and character codes for the integer literal parser
// no dependencies
package ilp_pkg;

	localparam int unsigned CharW  = 8;
	localparam int unsigned ValueW = 64;
	localparam int unsigned DigitW = 4;

	// characters with a meaning to the parser
	localparam logic [CharW-1:0] CH_END   = 8'h00;
	localparam logic [CharW-1:0] CH_MINUS = 8'h2d;
	localparam logic [CharW-1:0] CH_ZERO  = 8'h30;
	localparam logic [CharW-1:0] CH_ONE   = 8'h31;
	localparam logic [CharW-1:0] CH_SEVEN = 8'h37;
	localparam logic [CharW-1:0] CH_NINE  = 8'h39;
	localparam logic [CharW-1:0] CH_UP_A  = 8'h41;
	localparam logic [CharW-1:0] CH_UP_F  = 8'h46;
	localparam logic [CharW-1:0] CH_UNDER = 8'h5f;
	localparam logic [CharW-1:0] CH_LO_A  = 8'h61;
	localparam logic [CharW-1:0] CH_LO_B  = 8'h62;
	localparam logic [CharW-1:0] CH_LO_C  = 8'h63;
	localparam logic [CharW-1:0] CH_LO_F  = 8'h66;
	localparam logic [CharW-1:0] CH_LO_X  = 8'h78;

	// parse phase, one-hot
	typedef enum logic [3:0] {
		PH_START      = 4'b0001,
		PH_AFTER_SIGN = 4'b0010,
		PH_AFTER_ZERO = 4'b0100,
		PH_DIGITS     = 4'b1000
	} phase_t;

	typedef enum logic [1:0] {
		BASE_DEC = 2'd0,
		BASE_HEX = 2'd1,
		BASE_BIN = 2'd2,
		BASE_OCT = 2'd3
	} base_t;

	// finished literal handed from the parser core to the output register
	typedef struct packed {
		logic              valid;
		logic [ValueW-1:0] value;
	} result_t;

endpackage

/* rtl/ilp_core.sv */
// parser core: phase, base, sign and accumulator registers with the per-character update
// depends on ilp_pkg and integer_literal_parser_top_macros.svh
`include "integer_literal_parser_top_macros.svh"

module ilp_core import ilp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             take,
	input  logic [CharW-1:0] ch,
	output result_t          res
);

	phase_t            phase_q, phase_nxt;
	base_t             base_q, base_nxt;
	logic              neg_q, neg_nxt;
	logic [ValueW-1:0] acc_q, acc_nxt;
	logic              is_end;
	logic              use_digit;
	logic [DigitW-1:0] digit;
	logic [ValueW-1:0] acc_step;

	assign is_end = (ch == CH_END);

	// phase and base transitions
	always_comb begin
		phase_nxt = phase_q;
		base_nxt  = base_q;
		neg_nxt   = neg_q;
		use_digit = 1'b0;
		case (phase_q)
			PH_START, PH_AFTER_SIGN: begin
				if (phase_q == PH_START && ch == CH_MINUS) begin
					neg_nxt   = 1'b1;
					phase_nxt = PH_AFTER_SIGN;
				end else if (ch == CH_ZERO) begin
					phase_nxt = PH_AFTER_ZERO;
				end else begin
					base_nxt  = BASE_DEC;
					use_digit = 1'b1;
					phase_nxt = PH_DIGITS;
				end
			end
			PH_AFTER_ZERO: begin
				if (ch == CH_LO_X) begin
					base_nxt = BASE_HEX;
				end else if (ch == CH_LO_B) begin
					base_nxt = BASE_BIN;
				end else if (ch == CH_LO_C) begin
					base_nxt = BASE_OCT;
				end else begin
					// plain octal keeps this character as its first digit
					base_nxt  = BASE_OCT;
					use_digit = 1'b1;
				end
				phase_nxt = PH_DIGITS;
			end
			PH_DIGITS: begin
				use_digit = 1'b1;
			end
			default: begin
				phase_nxt = PH_START;
			end
		endcase
	end

	// digit value in the new base, zero for anything not a digit of it
	always_comb begin
		digit = '0;
		case (base_nxt)
			BASE_HEX: begin
				if (ch >= CH_ZERO && ch <= CH_NINE)
					digit = DigitW'(ch - CH_ZERO);
				else if (ch >= CH_UP_A && ch <= CH_UP_F)
					digit = DigitW'(ch - CH_UP_A + 8'd10);
				else if (ch >= CH_LO_A && ch <= CH_LO_F)
					digit = DigitW'(ch - CH_LO_A + 8'd10);
			end
			BASE_BIN: begin
				if (ch >= CH_ZERO && ch <= CH_ONE)
					digit = DigitW'(ch - CH_ZERO);
			end
			BASE_OCT: begin
				if (ch >= CH_ZERO && ch <= CH_SEVEN)
					digit = DigitW'(ch - CH_ZERO);
			end
			default: begin
				if (ch >= CH_ZERO && ch <= CH_NINE)
					digit = DigitW'(ch - CH_ZERO);
			end
		endcase
	end

	// shift or times-ten step, times ten as two shifts and an add
	always_comb begin
		case (base_nxt)
			BASE_HEX: acc_step = {acc_q[ValueW-5:0], 4'b0000} | ValueW'(digit);
			BASE_BIN: acc_step = {acc_q[ValueW-2:0], 1'b0} | ValueW'(digit);
			BASE_OCT: acc_step = {acc_q[ValueW-4:0], 3'b000} | ValueW'(digit);
			default:  acc_step = {acc_q[ValueW-4:0], 3'b000} + {acc_q[ValueW-2:0], 1'b0}
				+ ValueW'(digit);
		endcase
	end

	// underscores never touch the accumulator
	assign acc_nxt = (use_digit && ch != CH_UNDER) ? acc_step : acc_q;

	// state registers, cleared when the terminator is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			base_q  <= BASE_DEC;
			neg_q   <= 1'b0;
			acc_q   <= '0;
		end else if (take) begin
			if (is_end) begin
				phase_q <= PH_START;
				base_q  <= BASE_DEC;
				neg_q   <= 1'b0;
				acc_q   <= '0;
			end else begin
				phase_q <= phase_nxt;
				base_q  <= base_nxt;
				neg_q   <= neg_nxt;
				acc_q   <= acc_nxt;
			end
		end
	end

	// result on the terminator, negated when a sign was seen
	assign res.valid = take && is_end;
	assign res.value = neg_q ? (ValueW'(0) - acc_q) : acc_q;

	`ILP_ASSERT_NEXT(a_end_clears, take && is_end, phase_q == PH_START && acc_q == '0 && !neg_q,
		"terminator did not clear parser state")
	`ILP_ASSERT_NOW(a_sign_phase, neg_q, phase_q != PH_START,
		"sign flag set while still at start")
	`ILP_ASSERT_NOW(a_base_phase, base_q != BASE_DEC, phase_q == PH_DIGITS,
		"non-decimal base outside digit phase")

endmodule

/* rtl/ilp_out_reg.sv */
// output register holding one finished value until its transfer
// depends on ilp_pkg and integer_literal_parser_top_macros.svh
`include "integer_literal_parser_top_macros.svh"

module ilp_out_reg import ilp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  result_t           res,
	input  logic              value_stall,
	output logic              value_valid,
	output logic [ValueW-1:0] value,
	output logic              free
);

	logic              valid_q;
	logic [ValueW-1:0] value_q;

	// slot can take a new value when empty or when its value moves this cycle
	assign free = !valid_q || !value_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (free && res.valid) begin
			value_q <= res.value;
		end
	end

	assign value_valid = valid_q;
	assign value       = value_q;

	`ILP_ASSERT_NOW(a_no_overwrite, res.valid, free,
		"result offered while output slot is held")
	`ILP_ASSERT_NEXT(a_load_shows, res.valid && free, valid_q && value_q == $past(res.value),
		"loaded result not presented")
	`ILP_ASSERT_NEXT(a_drain, valid_q && !value_stall && !res.valid, !valid_q,
		"output slot not emptied after transfer")

endmodule

/* rtl/integer_literal_parser_top.sv */
// Integer literal parser: takes one character per transfer on ch and, on the zero
// byte, gives the signed 64-bit value of the literal on value. A leading '-' negates;
// "0x", "0b", "0c" select hex, binary, octal, any other character after a leading '0'
// starts plain octal, otherwise decimal. Underscores are skipped, characters that are
// not digits of the base count as zero, and the value wraps modulo 2^64. One character
// is accepted every cycle unless the input stalls; the accumulator update (a shift, or
// times ten as a shift-add) sets that rate. A terminator passes the input register, then
// the output register, before its value is presented; the input stalls only while a
// terminator in the input register waits behind a finished value held at a stalled output.
// depends on ilp_pkg, ilp_core, ilp_out_reg and integer_literal_parser_top_macros.svh
`include "integer_literal_parser_top_macros.svh"

module integer_literal_parser_top import ilp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              ch_valid,
	output logic              ch_stall,
	input  logic [CharW-1:0]  ch,
	output logic              value_valid,
	input  logic              value_stall,
	output logic signed [ValueW-1:0] value
);

	logic             valid_s1;
	logic [CharW-1:0] ch_s1;
	logic             take;
	logic             out_free;
	result_t          res;
	logic [ValueW-1:0] value_raw;

	// input register: holds a terminator while the output slot is held
	assign ch_stall = valid_s1 && (ch_s1 == CH_END) && !out_free;
	assign take     = valid_s1 && !ch_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!ch_stall) begin
			valid_s1 <= ch_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!ch_stall && ch_valid) begin
			ch_s1 <= ch;
		end
	end

	ilp_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.ch     (ch_s1),
		.res    (res)
	);

	ilp_out_reg u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.res         (res),
		.value_stall (value_stall),
		.value_valid (value_valid),
		.value       (value_raw),
		.free        (out_free)
	);

	assign value = signed'(value_raw);

	`ILP_ASSERT_NEXT(a_term_emits, take && ch_s1 == CH_END, value_valid,
		"terminator taken without a result")
	`ILP_ASSERT_NOW(a_stall_only_term, ch_stall, valid_s1 && ch_s1 == CH_END,
		"input stalled without a waiting terminator")
	`ILP_ASSERT_NOW(a_stall_cause, ch_stall, value_valid && value_stall,
		"input stalled while output is free")

endmodule
